FILE: rtl/rotation_matrix_to_euler_degrees_macros.svh
// Assertion macros for the orientation matrix to Euler angle block.
`ifndef ROTATION_MATRIX_TO_EULER_DEGREES_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_DEGREES_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RMTE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RMTE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rmte_pkg.sv
// Shared types, constants and functions for the orientation matrix to Euler angle block.
package rmte_pkg;

    localparam int GUARD = 8;
    localparam int XW    = 44;
    localparam int ZW    = 34;
    localparam int VW    = 34;
    localparam int PW    = ZW + 16;

    localparam logic signed [ZW-1:0] HALF_TURN    = 34'sh0_8000_0000;
    localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sh0_4000_0000;
    localparam logic [29:0]          INV_GAIN     = 30'd652032874;
    localparam logic [15:0]          CD_PER_TURN  = 16'd36000;
    localparam logic signed [18:0]   CD_MAX       = 19'sd18000;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_lane;

    typedef struct packed {
        logic                 spec;
        logic signed [ZW-1:0] ang;
        logic [VW-1:0]        mag;
        t_lane                lane;
    } t_pre;

    typedef struct packed {
        logic                 degen;
        logic signed [31:0]   r20;
        logic                 roll_spec;
        logic signed [ZW-1:0] roll_ang;
        logic [VW-1:0]        roll_mag;
        logic                 pitch_spec;
        logic signed [ZW-1:0] pitch_ang;
    } t_tag1;

    typedef struct packed {
        logic                 degen;
        logic signed [ZW-1:0] roll_ang;
        logic signed [ZW-1:0] pitch_ang;
        logic                 yaw_spec;
        logic signed [ZW-1:0] yaw_ang;
    } t_tag2;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic [31:0] atan_unit(input int unsigned idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Axis cases resolved exactly; left half plane pre-rotated by a quarter turn.
    function automatic t_pre cordic_pre(input logic signed [VW-1:0] x,
                                        input logic signed [VW-1:0] y);
        t_pre                 p;
        logic signed [XW-1:0] xe;
        logic signed [XW-1:0] ye;
        logic signed [XW-1:0] nx;
        logic signed [XW-1:0] ny;
        logic signed [ZW-1:0] z0;
        xe = XW'(x);
        ye = XW'(y);
        if (x < 0) begin
            if (y > 0) begin
                nx = ye;
                ny = -xe;
                z0 = QUARTER_TURN;
            end else begin
                nx = -ye;
                ny = xe;
                z0 = -QUARTER_TURN;
            end
        end else begin
            nx = xe;
            ny = ye;
            z0 = '0;
        end
        p.lane.x = nx <<< GUARD;
        p.lane.y = ny <<< GUARD;
        p.lane.z = z0;
        p.spec   = (x == 0) || (y == 0);
        if (y == 0) begin
            p.ang = (x < 0) ? HALF_TURN : '0;
            p.mag = (x < 0) ? VW'(-x) : VW'(x);
        end else if (x == 0) begin
            p.ang = (y > 0) ? QUARTER_TURN : -QUARTER_TURN;
            p.mag = (y < 0) ? VW'(-y) : VW'(y);
        end else begin
            p.ang = '0;
            p.mag = '0;
        end
        return p;
    endfunction

endpackage

FILE: rtl/rmte_cell.sv
// One vectoring CORDIC iteration over a set of lanes, with a passed-along tag.
module rmte_cell import rmte_pkg::*; #(
    parameter int STAGE = 0,
    parameter int LANES = 1,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_lane            i_lane [LANES],
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output t_lane            o_lane [LANES],
    output logic [TAG_W-1:0] o_tag
);

    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_unit(STAGE));

    logic             r_valid;
    t_lane            r_lane [LANES];
    t_lane            n_lane [LANES];
    logic [TAG_W-1:0] r_tag;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (i_lane[l].y > 0) begin
                n_lane[l].x = i_lane[l].x + (i_lane[l].y >>> STAGE);
                n_lane[l].y = i_lane[l].y - (i_lane[l].x >>> STAGE);
                n_lane[l].z = i_lane[l].z + ATAN;
            end else begin
                n_lane[l].x = i_lane[l].x - (i_lane[l].y >>> STAGE);
                n_lane[l].y = i_lane[l].y + (i_lane[l].x >>> STAGE);
                n_lane[l].z = i_lane[l].z - ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_lane <= n_lane;
            r_tag  <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
    assign o_tag   = r_tag;

endmodule

FILE: rtl/rmte_chain.sv
// Row of CORDIC cells, one iteration per cell.
module rmte_chain import rmte_pkg::*; #(
    parameter int STAGES = 24,
    parameter int LANES  = 1,
    parameter int TAG_W  = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_lane            i_lane [LANES],
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output t_lane            o_lane [LANES],
    output logic [TAG_W-1:0] o_tag
);

    logic             w_valid [STAGES+1];
    t_lane            w_lane  [STAGES+1][LANES];
    logic [TAG_W-1:0] w_tag   [STAGES+1];

    assign w_valid[0] = i_valid;
    assign w_lane[0]  = i_lane;
    assign w_tag[0]   = i_tag;

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        rmte_cell #(
            .STAGE (g),
            .LANES (LANES),
            .TAG_W (TAG_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[g]),
            .i_lane  (w_lane[g]),
            .i_tag   (w_tag[g]),
            .o_valid (w_valid[g+1]),
            .o_lane  (w_lane[g+1]),
            .o_tag   (w_tag[g+1])
        );
    end

    assign o_valid = w_valid[STAGES];
    assign o_lane  = w_lane[STAGES];
    assign o_tag   = w_tag[STAGES];

endmodule

FILE: rtl/rotation_matrix_to_euler_degrees.sv
// Top level: orientation matrix to pitch, yaw and roll in hundredths of a degree.
// Throughput: one item per cycle unless stalled; two rows of CORDIC_STAGES cells (roll and pitch, then yaw).
// Back-pressure stalls the whole pipeline; the output register holds a waiting item.
// Reset (synchronous, active low) clears only the valid bits of every stage.
module rotation_matrix_to_euler_degrees import rmte_pkg::*; #(
    parameter int FRAC_BITS     = 30,
    parameter int CORDIC_STAGES = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [223:0] i_s_tdata,  // r00, r10, r20, r11, r21, r12, r22 (32 bits each)
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [47:0]  o_m_tdata,  // pitch_centideg, yaw_centideg, roll_centideg
    output logic         o_m_tuser   // degenerate
);

    `include "rotation_matrix_to_euler_degrees_macros.svh"

    localparam logic [63:0] DEGEN_LIM = 64'd1 << (2 * (FRAC_BITS - 19));
    localparam int TAG1_W = $bits(t_tag1);
    localparam int TAG2_W = $bits(t_tag2);

    logic w_en;

    // input stage: squares
    logic signed [31:0]  w_in_r00, w_in_r10;
    logic signed [63:0]  n_s1_sq0, n_s1_sq1;
    logic                r_s1_valid;
    logic [63:0]         r_s1_sq0, r_s1_sq1;
    logic [223:0]        r_s1_data;

    // degenerate test
    logic                r_s2_valid, r_s2_degen;
    logic [223:0]        r_s2_data;
    logic signed [31:0]  w_s2_r00, w_s2_r10, w_s2_r20, w_s2_r11, w_s2_r21, w_s2_r12, w_s2_r22;
    t_pre                w_pre_roll, w_pre_pitch;
    t_tag1               w_tag1_in;
    t_lane               w_c1_in [2];

    logic                w_c1_valid;
    t_lane               w_c1_out [2];
    logic [TAG1_W-1:0]   w_c1_tag;
    t_tag1               w_tag1;

    // magnitude scaling
    logic [VW-1:0]       w_m;
    logic                r_mg_valid, r_mg_spec, r_mg_degen;
    logic [63:0]         r_mg_prod;
    logic [VW-1:0]       r_mg_smag;
    logic signed [31:0]  r_mg_r20;
    logic signed [ZW-1:0] r_mg_roll_ang, r_mg_pitch_ang;
    logic [63:0]         w_h_round;
    logic signed [VW-1:0] w_h;
    t_pre                w_pre_yaw;
    t_tag2               w_tag2_in;
    t_lane               w_c2_in [1];

    logic                w_c2_valid;
    t_lane               w_c2_out [1];
    logic [TAG2_W-1:0]   w_c2_tag;
    t_tag2               w_tag2;

    // centidegree scaling: index 0 pitch, 1 yaw, 2 roll
    logic signed [ZW-1:0] w_ang [3];
    logic [ZW-1:0]       w_abs [3];
    logic                r_cd_valid, r_cd_degen;
    logic [PW-1:0]       r_cd_prod [3];
    logic                r_cd_neg [3];
    logic [PW-1:0]       w_q_full [3];
    logic [17:0]         w_q [3];
    logic signed [18:0]  w_r [3];
    logic [15:0]         w_cd [3];

    logic                r_out_valid, r_out_degen;
    logic [15:0]         r_out_pitch, r_out_yaw, r_out_roll;

    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    assign w_in_r00 = i_s_tdata[31:0];
    assign w_in_r10 = i_s_tdata[63:32];
    assign n_s1_sq0 = w_in_r00 * w_in_r00;
    assign n_s1_sq1 = w_in_r10 * w_in_r10;

    assign w_s2_r00 = r_s2_data[31:0];
    assign w_s2_r10 = r_s2_data[63:32];
    assign w_s2_r20 = r_s2_data[95:64];
    assign w_s2_r11 = r_s2_data[127:96];
    assign w_s2_r21 = r_s2_data[159:128];
    assign w_s2_r12 = r_s2_data[191:160];
    assign w_s2_r22 = r_s2_data[223:192];

    always_comb begin
        w_pre_roll = cordic_pre(VW'(w_s2_r00), VW'(w_s2_r10));
        if (r_s2_degen) begin
            w_pre_pitch = cordic_pre(VW'(w_s2_r11), -VW'(w_s2_r12));
        end else begin
            w_pre_pitch = cordic_pre(VW'(w_s2_r22), VW'(w_s2_r21));
        end
        w_tag1_in.degen      = r_s2_degen;
        w_tag1_in.r20        = w_s2_r20;
        w_tag1_in.roll_spec  = w_pre_roll.spec;
        w_tag1_in.roll_ang   = w_pre_roll.ang;
        w_tag1_in.roll_mag   = w_pre_roll.mag;
        w_tag1_in.pitch_spec = w_pre_pitch.spec;
        w_tag1_in.pitch_ang  = w_pre_pitch.ang;
        w_c1_in[0]           = w_pre_roll.lane;
        w_c1_in[1]           = w_pre_pitch.lane;
    end

    rmte_chain #(
        .STAGES (CORDIC_STAGES),
        .LANES  (2),
        .TAG_W  (TAG1_W)
    ) u_chain_rp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_valid),
        .i_lane  (w_c1_in),
        .i_tag   (w_tag1_in),
        .o_valid (w_c1_valid),
        .o_lane  (w_c1_out),
        .o_tag   (w_c1_tag)
    );

    assign w_tag1 = t_tag1'(w_c1_tag);
    assign w_m    = VW'((w_c1_out[0].x + XW'(1 << (GUARD - 1))) >>> GUARD);

    assign w_h_round = (r_mg_prod + 64'd536870912) >> 30;
    assign w_h       = r_mg_spec ? r_mg_smag : w_h_round[VW-1:0];

    always_comb begin
        w_pre_yaw          = cordic_pre(w_h, -VW'(r_mg_r20));
        w_tag2_in.degen     = r_mg_degen;
        w_tag2_in.roll_ang  = r_mg_roll_ang;
        w_tag2_in.pitch_ang = r_mg_pitch_ang;
        w_tag2_in.yaw_spec  = w_pre_yaw.spec;
        w_tag2_in.yaw_ang   = w_pre_yaw.ang;
        w_c2_in[0]          = w_pre_yaw.lane;
    end

    rmte_chain #(
        .STAGES (CORDIC_STAGES),
        .LANES  (1),
        .TAG_W  (TAG2_W)
    ) u_chain_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_mg_valid),
        .i_lane  (w_c2_in),
        .i_tag   (w_tag2_in),
        .o_valid (w_c2_valid),
        .o_lane  (w_c2_out),
        .o_tag   (w_c2_tag)
    );

    assign w_tag2 = t_tag2'(w_c2_tag);

    always_comb begin
        w_ang[0] = w_tag2.pitch_ang;
        w_ang[1] = w_tag2.yaw_spec ? w_tag2.yaw_ang : w_c2_out[0].z;
        w_ang[2] = w_tag2.roll_ang;
        for (int a = 0; a < 3; a++) begin
            w_abs[a]    = (w_ang[a] < 0) ? ZW'(-w_ang[a]) : ZW'(w_ang[a]);
            w_q_full[a] = (r_cd_prod[a] + PW'(64'd2147483648)) >> 32;
            w_q[a]      = w_q_full[a][17:0];
            w_r[a]      = r_cd_neg[a] ? -$signed({1'b0, w_q[a]}) : $signed({1'b0, w_q[a]});
            if (w_r[a] <= -CD_MAX || w_r[a] > CD_MAX) begin
                w_r[a] = CD_MAX;
            end
            w_cd[a] = w_r[a][15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_mg_valid  <= 1'b0;
            r_cd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid  <= i_s_tvalid;
            r_s2_valid  <= r_s1_valid;
            r_mg_valid  <= w_c1_valid;
            r_cd_valid  <= w_c2_valid;
            r_out_valid <= r_cd_valid;
        end
        if (w_en) begin
            r_s1_sq0   <= n_s1_sq0;
            r_s1_sq1   <= n_s1_sq1;
            r_s1_data  <= i_s_tdata;
            r_s2_degen <= (r_s1_sq0 + r_s1_sq1) <= DEGEN_LIM;
            r_s2_data  <= r_s1_data;

            r_mg_prod      <= 64'(w_m) * 64'(INV_GAIN);
            r_mg_spec      <= w_tag1.roll_spec;
            r_mg_smag      <= w_tag1.roll_mag;
            r_mg_degen     <= w_tag1.degen;
            r_mg_r20       <= w_tag1.r20;
            r_mg_roll_ang  <= w_tag1.roll_spec ? w_tag1.roll_ang : w_c1_out[0].z;
            r_mg_pitch_ang <= w_tag1.pitch_spec ? w_tag1.pitch_ang : w_c1_out[1].z;

            for (int a = 0; a < 3; a++) begin
                r_cd_prod[a] <= PW'(w_abs[a]) * PW'(CD_PER_TURN);
                r_cd_neg[a]  <= w_ang[a] < 0;
            end
            r_cd_degen <= w_tag2.degen;

            r_out_pitch <= w_cd[0];
            r_out_yaw   <= w_cd[1];
            r_out_roll  <= r_cd_degen ? 16'd0 : w_cd[2];
            r_out_degen <= r_cd_degen;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_roll, r_out_yaw, r_out_pitch};
    assign o_m_tuser  = r_out_degen;

    `RMTE_ASSERT_IMP(a_degen_roll_zero, o_m_tvalid && o_m_tuser, o_m_tdata[47:32] == 16'd0, "roll not zero on degenerate item")
    `RMTE_ASSERT_IMP(a_pitch_range, o_m_tvalid, ($signed(o_m_tdata[15:0]) > -16'sd18000) && ($signed(o_m_tdata[15:0]) <= 16'sd18000), "pitch out of range")
    `RMTE_ASSERT_IMP(a_yaw_range, o_m_tvalid, ($signed(o_m_tdata[31:16]) > -16'sd18000) && ($signed(o_m_tdata[31:16]) <= 16'sd18000), "yaw out of range")
    `RMTE_ASSERT_NXT(a_last_stage_moves, r_cd_valid && w_en, o_m_tvalid, "item lost at output register")

endmodule

FILE: tb/sv/rotation_matrix_to_euler_degrees_test.sv
// Self-checking testbench for the matrix to Euler angle block: directed and random items.
`timescale 1ns / 1ps

module rotation_matrix_to_euler_degrees_test;
    import rmte_pkg::*;

    localparam int STAGES    = 24;
    localparam int LATENCY   = 2 * STAGES + 5;
    localparam int WDOG_MAX  = 20000;
    localparam longint ONE   = 64'sd1073741824;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic               degen;
    } t_angles;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [223:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [47:0]  o_m_tdata;
    logic         o_m_tuser;

    t_angles angles_due[$];
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_off;
    int      mismatches;
    int      results_seen;
    int      items_sent;
    int      degen_seen;
    int      quiet_cycles;

    const longint atan_tab[24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    rotation_matrix_to_euler_degrees u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    // angle (2^32 per turn) and gain-corrected magnitude of the vector (x, y)
    function automatic void vector_angle(input longint x, input longint y,
                                         output longint ang, output longint mag);
        longint z, t, dx, dy, m;
        z = 0;
        if (y == 0) begin
            ang = (x < 0) ? 64'sd2147483648 : 0;
            mag = (x < 0) ? -x : x;
            return;
        end
        if (x == 0) begin
            ang = (y > 0) ? ONE : -ONE;
            mag = (y < 0) ? -y : y;
            return;
        end
        if (x < 0) begin
            t = x;
            if (y > 0) begin
                x = y; y = -t; z = ONE;
            end else begin
                x = -y; y = t; z = -ONE;
            end
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < STAGES; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += atan_tab[i];
            end else begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        m = (x + 128) >>> 8;
        mag = (m * 64'sd652032874 + (64'sd1 << 29)) >>> 30;
        ang = z;
    endfunction

    function automatic logic signed [15:0] centideg(input longint z);
        longint a, q, r;
        a = (z < 0) ? -z : z;
        q = (a * 36000 + 64'sd2147483648) >>> 32;
        r = (z < 0) ? -q : q;
        if (r <= -18000 || r > 18000) r = 18000;
        return 16'(r);
    endfunction

    function automatic t_angles euler_of(input logic [223:0] d);
        longint r00, r10, r20, r11, r21, r12, r22;
        longint h, roll_a, yaw_a, pitch_a, unused;
        t_angles e;
        r00 = longint'($signed(d[31:0]));
        r10 = longint'($signed(d[63:32]));
        r20 = longint'($signed(d[95:64]));
        r11 = longint'($signed(d[127:96]));
        r21 = longint'($signed(d[159:128]));
        r12 = longint'($signed(d[191:160]));
        r22 = longint'($signed(d[223:192]));
        e.degen = (64'(r00 * r00) + 64'(r10 * r10)) <= 64'd4194304;
        vector_angle(r00, r10, roll_a, h);
        vector_angle(h, -r20, yaw_a, unused);
        if (e.degen) begin
            vector_angle(r11, -r12, pitch_a, unused);
            e.roll = '0;
        end else begin
            vector_angle(r22, r21, pitch_a, unused);
            e.roll = centideg(roll_a);
        end
        e.pitch = centideg(pitch_a);
        e.yaw   = centideg(yaw_a);
        return e;
    endfunction

    task automatic send_matrix(input logic [223:0] d);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        angles_due.insert(angles_due.size(), euler_of(d));
        items_sent++;
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(8)) - 4);
            3: return 32'($signed($urandom_range(4096)) - 2048);
            4: return $urandom();
            default: return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
        endcase
    endfunction

    // proper rotation built from the given angles, quantised to Q1.30
    function automatic logic [223:0] rotation_matrix(input real p, input real y, input real r);
        real cp, sp, cy, sy, cr, sr;
        logic [223:0] d;
        cp = $cos(p); sp = $sin(p); cy = $cos(y); sy = $sin(y); cr = $cos(r); sr = $sin(r);
        d[31:0]    = 32'($rtoi(cy * cr * 1073741824.0));
        d[63:32]   = 32'($rtoi(cy * sr * 1073741824.0));
        d[95:64]   = 32'($rtoi(-sy * 1073741824.0));
        d[127:96]  = 32'($rtoi((sp * sy * sr + cp * cr) * 1073741824.0));
        d[159:128] = 32'($rtoi(sp * cy * 1073741824.0));
        d[191:160] = 32'($rtoi((cp * sy * sr - sp * cr) * 1073741824.0));
        d[223:192] = 32'($rtoi(cp * cy * 1073741824.0));
        return d;
    endfunction

    function automatic real rand_angle();
        return ($urandom_range(62831) - 31415) / 10000.0;
    endfunction

    task automatic test_extremes();
        logic [31:0] v[6] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h4000_0000,
                               32'hC000_0000, 32'hFFFF_FFFF};
        send_matrix('0);
        for (int k = 0; k < 6; k++) send_matrix({7{v[k]}});
        send_matrix({32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF});
        send_matrix({32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000});
    endtask

    task automatic test_degenerate_edge();
        // squared norm just at and just past the limit
        send_matrix({32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'd2048});
        send_matrix({32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'd2049});
        send_matrix({32'h4000_0000, 32'h3000_0000, 32'h0, 32'hC000_0000, 32'h0, 32'h0,
                     -32'd2048});
        send_matrix({32'h0, 32'h1, 32'h4000_0000, 32'h0, 32'h1234_5678, 32'd1200, 32'd1600});
        send_matrix({32'h0, 32'h0, 32'hC000_0000, 32'h0, 32'h0, 32'h0, 32'h0});
    endtask

    task automatic test_axes_and_half_turn();
        send_matrix({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hC000_0000});
        send_matrix({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000});
        send_matrix({32'hC000_0000, 32'h4000_0000, 32'hC000_0000, 32'h0, 32'hFFFF_FFFF,
                     32'h0, 32'h4000_0000});
        send_matrix({32'hC000_0000, 32'h4000_0000, 32'hC000_0000, 32'h0, 32'h1, 32'h0,
                     32'hC000_0000});
        send_matrix({32'hC000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hC000_0000, 32'h0,
                     32'h0000_0001});
        send_matrix(rotation_matrix(1.0, 0.5, -2.5));
        send_matrix(rotation_matrix(-3.1, 1.5707, 3.14));
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(9) < 6)
                send_matrix(rotation_matrix(rand_angle(), rand_angle(), rand_angle()));
            else if ($urandom_range(3) == 0)
                send_matrix({rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                             32'($signed($urandom_range(4)) - 2),
                             32'($signed($urandom_range(4)) - 2)});
            else
                send_matrix({rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                             rand_elem(), rand_elem()});
        end
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        send_idle_pct = 0;
        test_random(120);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off   <= hold_off - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_angles got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata, o_m_tuser};
            results_seen++;
            if (got.degen) degen_seen++;
            if (angles_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %h", got);
            end else begin
                want = angles_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("item %0d: pitch %0d/%0d yaw %0d/%0d roll %0d/%0d degen %b/%b",
                                 results_seen, want.pitch, got.pitch, want.yaw, got.yaw,
                                 want.roll, got.roll, want.degen, got.degen);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_MAX) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        send_idle_pct = 22;
        recv_idle_pct = 75;
        hold_off      = 0;
        mismatches    = 0;
        results_seen  = 0;
        items_sent    = 0;
        degen_seen    = 0;
        quiet_cycles  = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_degenerate_edge();
        test_axes_and_half_turn();
        test_random(160);
        send_idle_pct = 75;
        recv_idle_pct = 22;
        test_random(160);
        recv_idle_pct = 0;
        test_backpressure();
        test_random(140);
        i_s_tvalid <= 1'b0;
        while (angles_due.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d matrices (%0d degenerate results), random rotations and raw patterns,",
                 items_sent, degen_seen);
        $display("with idling on both sides and one long output stall.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
